>>> design/mf3_pkg.sv
// Shared types and constants for the 3x3 max filter.
package mf3_pkg;

    localparam int WINDOW = 3;

    typedef struct packed {
        logic rd_en;
        logic adv;
    } t_lb_ctrl;

endpackage

>>> design/mf3_window.sv
// Line store memory and column maxima that form the 3x3 window maximum.
module mf3_window
    import mf3_pkg::*;
#(
    parameter int MAX_SIDE   = 128,
    parameter int PIXEL_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lb_ctrl                    i_ctrl,
    input  logic [$clog2(MAX_SIDE)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_SIDE)-1:0] i_wr_addr,
    input  logic [PIXEL_BITS-1:0]       i_pixel,
    output logic [PIXEL_BITS-1:0]       o_win_max
);

    localparam int POS_W = $clog2(MAX_SIDE);

    logic [2*PIXEL_BITS-1:0] mem [MAX_SIDE];
    logic [2*PIXEL_BITS-1:0] r_rd_data;
    logic [PIXEL_BITS-1:0]   r_cm1;
    logic [PIXEL_BITS-1:0]   r_cm2;
    logic [PIXEL_BITS-1:0]   w_older;
    logic [PIXEL_BITS-1:0]   w_newer;
    logic [PIXEL_BITS-1:0]   w_top2;
    logic [PIXEL_BITS-1:0]   w_col_max;
    logic [PIXEL_BITS-1:0]   w_back2;

    // Each entry holds the row two above in the upper half and the row above in the lower half.
    assign w_older   = r_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign w_newer   = r_rd_data[PIXEL_BITS-1:0];
    assign w_top2    = (w_older > w_newer) ? w_older : w_newer;
    assign w_col_max = (w_top2 > i_pixel) ? w_top2 : i_pixel;
    assign w_back2   = (r_cm1 > r_cm2) ? r_cm1 : r_cm2;
    assign o_win_max = (w_col_max > w_back2) ? w_col_max : w_back2;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_ctrl.adv) begin
            mem[i_wr_addr] <= {w_newer, i_pixel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm1 <= '0;
            r_cm2 <= '0;
        end else if (i_ctrl.adv) begin
            r_cm2 <= r_cm1;
            r_cm1 <= w_col_max;
        end
    end

    a_addr_width : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.adv |-> (32'(i_wr_addr) < MAX_SIDE && 32'(POS_W) > 0))
        else $error("line store write address out of range");

    a_cm_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.adv |=> (r_cm2 === $past(r_cm1)))
        else $error("column maxima did not shift on advance");

    a_cm_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.adv |=> ((r_cm1 === $past(r_cm1)) && (r_cm2 === $past(r_cm2))))
        else $error("column maxima changed without advance");

endmodule

>>> design/max_filter_3x3_top.sv
// Top level of the 3x3 max filter over a square image streamed in raster order.
// Each accepted pixel is held in the input stage register and moves on to the output
// register when that register is empty or its result is being taken.
// Throughput: one pixel per cycle while the output is taken; the line store memory is read at
// acceptance and written when the item advances to the output register.
// Reset: synchronous and active low; it clears positions, column maxima and valids,
// and sets the side length to 3. The line store is not cleared.
module max_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_SIDE   = 128,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_grid_size,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_BITS-1:0] o_max_value,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int POS_W  = $clog2(MAX_SIDE);

    typedef struct packed {
        logic emit;
        logic eor;
        logic eof;
    } t_res_flags;

    logic [POS_W-1:0]      r_last;
    logic [POS_W-1:0]      n_last;
    logic [SIDE_W-1:0]     w_side;
    logic [POS_W-1:0]      r_row;
    logic [POS_W-1:0]      r_col;
    logic                  r_a_valid;
    logic [PIXEL_BITS-1:0] r_a_px;
    logic [POS_W-1:0]      r_a_col;
    t_res_flags            r_a_flags;
    t_res_flags            w_flags;
    logic                  r_o_valid;
    logic [PIXEL_BITS-1:0] r_o_max;
    logic                  r_o_eor;
    logic                  r_o_eof;
    logic                  w_adv;
    logic                  w_in_acc;
    logic [PIXEL_BITS-1:0] w_win_max;
    t_lb_ctrl              w_ctrl;

    always_comb begin
        priority if (i_cfg_grid_size < 8'(WINDOW)) begin
            w_side = SIDE_W'(WINDOW);
        end else if (32'(i_cfg_grid_size) > MAX_SIDE) begin
            w_side = SIDE_W'(MAX_SIDE);
        end else begin
            w_side = SIDE_W'(i_cfg_grid_size);
        end
        n_last = POS_W'(w_side - 1'b1);
    end

    assign w_adv      = r_a_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_flags.emit = (r_row >= POS_W'(WINDOW - 1)) && (r_col >= POS_W'(WINDOW - 1));
    assign w_flags.eor  = (r_col == r_last);
    assign w_flags.eof  = (r_col == r_last) && (r_row == r_last);

    assign w_ctrl.rd_en = w_in_acc;
    assign w_ctrl.adv   = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= POS_W'(WINDOW - 1);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_last <= n_last;
            r_row  <= '0;
            r_col  <= '0;
        end else if (w_in_acc) begin
            if (r_col == r_last) begin
                r_col <= '0;
                r_row <= (r_row == r_last) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_flags <= '0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
            r_a_flags <= w_flags;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_px  <= i_pixel;
            r_a_col <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_a_flags.emit;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_max <= w_win_max;
            r_o_eor <= r_a_flags.eor;
            r_o_eof <= r_a_flags.eof;
        end
    end

    mf3_window #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_rd_addr  (r_col),
        .i_wr_addr  (r_a_col),
        .i_pixel    (r_a_px),
        .o_win_max  (w_win_max)
    );

    assign o_out_valid    = r_o_valid;
    assign o_max_value    = r_o_max;
    assign o_end_of_row   = r_o_eor;
    assign o_end_of_frame = r_o_eof;

    a_eof_on_eor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_end_of_frame || o_end_of_row))
        else $error("end of frame without end of row");

    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last)
        else $error("column position beyond side length");

    a_row_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last)
        else $error("row position beyond side length");

    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_a_valid) |-> w_adv)
        else $error("request accepted into an occupied stage");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 max filter: directed frames, side length corners and random streams.
module tb_top
    import mf3_pkg::*;
();

    localparam int MAX_SIDE   = 128;
    localparam int PIXEL_BITS = 8;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] max_value;
        logic                  end_of_row;
        logic                  end_of_frame;
    } t_window_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [7:0]            i_cfg_grid_size;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [PIXEL_BITS-1:0] i_pixel;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIXEL_BITS-1:0] o_max_value;
    logic                  o_end_of_row;
    logic                  o_end_of_frame;

    logic [PIXEL_BITS-1:0] row_above2 [MAX_SIDE];
    logic [PIXEL_BITS-1:0] row_above1 [MAX_SIDE];
    logic [PIXEL_BITS-1:0] col_max_back1;
    logic [PIXEL_BITS-1:0] col_max_back2;
    int unsigned           pos_row;
    int unsigned           pos_col;
    logic [7:0]            side_reg;

    t_window_result        window_max_q [$];
    int unsigned           mismatches = 0;
    int unsigned           stall_left = 0;
    bit                    bursts_on  = 1'b1;

    max_filter_3x3_top #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_grid_size (i_cfg_grid_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_max_value     (o_max_value),
        .o_end_of_row    (o_end_of_row),
        .o_end_of_frame  (o_end_of_frame)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [PIXEL_BITS-1:0] larger(input logic [PIXEL_BITS-1:0] a,
                                                     input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic int unsigned side_len();
        if (side_reg < WINDOW) begin
            return WINDOW;
        end
        if (side_reg > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return 32'(side_reg);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return PIXEL_BITS'($urandom_range(0, (1 << PIXEL_BITS) - 1));
            end
        endcase
    endfunction

    // Works out the window maximum for one accepted pixel and advances the position.
    task automatic dilate_pixel(input logic [PIXEL_BITS-1:0] px);
        int unsigned           n;
        logic [PIXEL_BITS-1:0] col_max;
        t_window_result        res;
        n = side_len();
        col_max = larger(larger(row_above2[pos_col], row_above1[pos_col]), px);
        if (pos_row >= 2 && pos_col >= 2) begin
            res.max_value    = larger(larger(col_max, col_max_back1), col_max_back2);
            res.end_of_row   = (pos_col == n - 1);
            res.end_of_frame = (pos_col == n - 1) && (pos_row == n - 1);
            window_max_q.push_back(res);
        end
        row_above2[pos_col] = row_above1[pos_col];
        row_above1[pos_col] = px;
        col_max_back2 = col_max_back1;
        col_max_back1 = col_max;
        if (pos_col + 1 >= n) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= n) ? 0 : pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
        int unsigned gap;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        do @(posedge i_clk); while (!o_in_ready);
        dilate_pixel(px);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (window_max_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [7:0] value);
        drain_results();
        i_cfg_we        <= 1'b1;
        i_cfg_grid_size <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        side_reg = value;
        pos_row  = 0;
        pos_col  = 0;
    endtask

    // Two back-to-back frames at the reset side length of three.
    task automatic test_reset_side_frames();
        logic [PIXEL_BITS-1:0] pixels [18];
        pixels = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h02, 8'h10, 8'h20, 8'h7F};
        foreach (pixels[k]) begin
            send_pixel(pixels[k]);
        end
    endtask

    // Side lengths below three and above the maximum are clamped.
    task automatic test_side_clamp();
        write_grid(8'd0);
        repeat (9) send_pixel('0);
        write_grid(8'd1);
        send_random(9);
        write_grid(8'd2);
        send_random(9);
        write_grid(8'd255);
        send_random(3 * MAX_SIDE);
    endtask

    // A write in the middle of a frame restarts the frame with the next pixel.
    task automatic test_restart_mid_frame();
        write_grid(8'd5);
        send_random(17);
        write_grid(8'd5);
        send_random(25);
        write_grid(8'd6);
        send_random(2 * 36);
    endtask

    task automatic test_random_streams();
        int unsigned random_items;
        int unsigned side;
        int unsigned total;
        logic [7:0]  grid;
        random_items = 0;
        while (random_items < 300) begin
            if ($urandom_range(0, 9) == 0) begin
                grid = 8'($urandom_range(0, 2));
            end else if ($urandom_range(0, 3) == 0) begin
                grid = 8'($urandom_range(11, 20));
            end else begin
                grid = 8'($urandom_range(3, 10));
            end
            bursts_on = ($urandom_range(0, 4) != 0);
            write_grid(grid);
            side  = (grid < WINDOW) ? WINDOW : 32'(grid);
            total = $urandom_range(1, 3) * side * side;
            if ($urandom_range(0, 4) == 0) begin
                total = total - $urandom_range(1, side * side - 1);
            end
            if (total > 300 - random_items) begin
                total = 300 - random_items;
            end
            send_random(total);
            random_items += total;
        end
    endtask

    // The last frame runs without idling on either side.
    task automatic test_no_idle_frame();
        bursts_on = 1'b0;
        write_grid(8'd10);
        send_random(100);
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (window_max_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 50) begin
                    $display("%0t: unexpected request result: expected none, actual %h/%b/%b",
                             $time, o_max_value, o_end_of_row, o_end_of_frame);
                end
            end else begin
                want = window_max_q.pop_front();
                if (o_max_value !== want.max_value) begin
                    mismatches++;
                    if (mismatches <= 50) begin
                        $display("%0t: max_value: expected %h, actual %h",
                                 $time, want.max_value, o_max_value);
                    end
                end
                if (o_end_of_row !== want.end_of_row) begin
                    mismatches++;
                    if (mismatches <= 50) begin
                        $display("%0t: end_of_row: expected %b, actual %b",
                                 $time, want.end_of_row, o_end_of_row);
                    end
                end
                if (o_end_of_frame !== want.end_of_frame) begin
                    mismatches++;
                    if (mismatches <= 50) begin
                        $display("%0t: end_of_frame: expected %b, actual %b",
                                 $time, want.end_of_frame, o_end_of_frame);
                    end
                end
            end
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_grid_size = 8'd3;
        i_in_valid      = 1'b0;
        i_pixel         = '0;
        i_out_ready     = 1'b0;
        foreach (row_above2[k]) begin
            row_above2[k] = '0;
            row_above1[k] = '0;
        end
        col_max_back1 = '0;
        col_max_back2 = '0;
        pos_row       = 0;
        pos_col       = 0;
        side_reg      = 8'd3;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_side_frames();
        test_side_clamp();
        test_restart_mid_frame();
        test_random_streams();
        test_no_idle_frame();
        drain_results();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
